// ===== hw/rtl/glos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glos_pkg
// Shared constants, codes and control types of the grid line-of-sight unit.
// ----------------------------------------------------------------------------
package glos_pkg;

  // coordinate fields are fixed at six bits
  localparam int GLOS_COORD_W = 6;
  // error term: covers 2*err with margin for coordinates of GLOS_COORD_W bits
  localparam int GLOS_ERR_W   = GLOS_COORD_W + 3;

  // stream widths
  localparam int GLOS_IN_DATA_W  = 32;
  localparam int GLOS_OUT_DATA_W = 8;

  // default map size
  localparam int GLOS_MAP_COLS_DEF = 64;
  localparam int GLOS_MAP_ROWS_DEF = 64;

  // request kinds
  localparam logic GLOS_CMD_WRITE = 1'b0;
  localparam logic GLOS_CMD_QUERY = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;  // write one wall cell of the clearing sweep
    logic load;      // capture an accepted request
    logic map_write; // write the wall bit of the accepted request
    logic step;      // advance the line by one cell
    logic load_out;  // move the answer into the output register
  } glos_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last; // sweep is at the last map entry
    logic same_cell;  // request start and end cells coincide
    logic step_end;   // the current step lands on the end cell
    logic out_free;   // output register can take an answer this cycle
  } glos_sts_t;

endpackage

// ===== hw/rtl/glos_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glos_ctrl
// Sequencer: clearing sweep after reset, request intake, line walk, answer.
// ----------------------------------------------------------------------------
module glos_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  glos_pkg::glos_sts_t sts,
  output glos_pkg::glos_cmd_t cmd
);
  import glos_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_command == GLOS_CMD_WRITE) begin
            cmd.map_write = 1'b1;
            state_next    = ST_DONE;
          end else if (sts.same_cell) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.step_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/glos_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glos_dp
// Datapath: wall map memory, Bresenham stepper, wall check, output register.
// ----------------------------------------------------------------------------
module glos_dp #(
  parameter int unsigned MAP_COLS = glos_pkg::GLOS_MAP_COLS_DEF,
  parameter int unsigned MAP_ROWS = glos_pkg::GLOS_MAP_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  glos_pkg::glos_cmd_t               cmd,
  output glos_pkg::glos_sts_t               sts,
  input  logic                              in_command,
  input  logic [glos_pkg::GLOS_COORD_W-1:0] in_start_col,
  input  logic [glos_pkg::GLOS_COORD_W-1:0] in_start_row,
  input  logic [glos_pkg::GLOS_COORD_W-1:0] in_end_col,
  input  logic [glos_pkg::GLOS_COORD_W-1:0] in_end_row,
  input  logic                              in_wall_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_line_clear,
  output logic                              out_answered_command
);
  import glos_pkg::*;

  localparam int unsigned DEPTH = MAP_COLS * MAP_ROWS;
  localparam int          AW    = $clog2(DEPTH);
  localparam int          CW    = GLOS_COORD_W;
  localparam int          EW    = GLOS_ERR_W;

  // wall map
  logic          wall_mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic          in_inside;
  logic [AW-1:0] rd_addr;
  logic          rd_data;

  // walk registers
  logic [CW-1:0]        x;
  logic [CW-1:0]        y;
  logic [CW-1:0]        x0;
  logic [CW-1:0]        y0;
  logic [CW-1:0]        x1;
  logic [CW-1:0]        y1;
  logic                 sx;
  logic                 sy;
  logic signed [EW-1:0] dx;
  logic signed [EW-1:0] dy;
  logic signed [EW-1:0] err;
  logic                 cmd_q;
  logic                 chk_vld;
  logic                 chk_oob;
  logic                 blocked;

  // load-time values
  logic [CW-1:0]        dx_in;
  logic [CW-1:0]        dy_in;

  // step logic
  logic signed [EW:0]   e2;
  logic                 x_move;
  logic                 y_move;
  logic [CW-1:0]        x_next;
  logic [CW-1:0]        y_next;
  logic signed [EW-1:0] err_next;
  logic                 nxt_inner;
  logic                 nxt_oob;

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign sts.clear_last = (32'(clr_addr) == DEPTH - 1);

  // write port: sweep writes wall, requests write their own value
  assign in_inside = (32'(in_start_col) < MAP_COLS) && (32'(in_start_row) < MAP_ROWS);
  assign wr_en     = cmd.clear_en || (cmd.map_write && in_inside);
  assign wr_addr   = cmd.clear_en ? clr_addr
                                  : AW'(32'(in_start_row) * MAP_COLS + 32'(in_start_col));
  assign wr_data   = cmd.clear_en ? 1'b1 : in_wall_value;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wall_mem[wr_addr] <= wr_data;
    end
  end

  // request decode
  assign dx_in = (in_end_col > in_start_col) ? (in_end_col - in_start_col)
                                             : (in_start_col - in_end_col);
  assign dy_in = (in_end_row > in_start_row) ? (in_end_row - in_start_row)
                                             : (in_start_row - in_end_row);
  assign sts.same_cell = (in_start_col == in_end_col) && (in_start_row == in_end_row);

  // one Bresenham step
  assign e2       = {err, 1'b0};
  assign x_move   = (e2 > -(EW + 1)'(dy));
  assign y_move   = (e2 < (EW + 1)'(dx));
  assign x_next   = x_move ? (sx ? x + CW'(1) : x - CW'(1)) : x;
  assign y_next   = y_move ? (sy ? y + CW'(1) : y - CW'(1)) : y;
  assign err_next = err - (x_move ? dy : '0) + (y_move ? dx : '0);

  assign sts.step_end = (x_next == x1) && (y_next == y1);
  assign nxt_inner    = ((x_next != x0) || (y_next != y0)) && !sts.step_end;
  assign nxt_oob      = (32'(x_next) >= MAP_COLS) || (32'(y_next) >= MAP_ROWS);
  assign rd_addr      = nxt_oob ? '0 : AW'(32'(y_next) * MAP_COLS + 32'(x_next));

  // registered map read for the cell just stepped to
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_data <= wall_mem[rd_addr];
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= in_start_col;
      y     <= in_start_row;
      x0    <= in_start_col;
      y0    <= in_start_row;
      x1    <= in_end_col;
      y1    <= in_end_row;
      sx    <= (in_start_col < in_end_col);
      sy    <= (in_start_row < in_end_row);
      dx    <= EW'(dx_in);
      dy    <= EW'(dy_in);
      err   <= EW'(dx_in) - EW'(dy_in);
      cmd_q <= in_command;
    end else if (cmd.step) begin
      x     <= x_next;
      y     <= y_next;
      err   <= err_next;
    end
  end

  // wall check on the registered map read of each step
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
      chk_oob <= 1'b0;
      blocked <= 1'b0;
    end else begin
      chk_vld <= cmd.step && nxt_inner;
      chk_oob <= nxt_oob;
      if (cmd.load) begin
        blocked <= 1'b0;
      end else if (chk_vld && (chk_oob || rd_data)) begin
        blocked <= 1'b1;
      end
    end
  end

  // output register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_line_clear       <= (cmd_q == GLOS_CMD_QUERY) && !blocked;
      out_answered_command <= cmd_q;
    end
  end

endmodule

// ===== hw/rtl/grid_line_of_sight_unit.sv =====
`timescale 1ns / 1ps
// Answer: a write goes straight to the answer state; a query first walks the line,
//   one map read per step, and the answer is loaded once the output register is free.
// Requests: one request at a time; a new request is taken in the cycle after
//   the answer enters the output register.
// Reset: after rst the map is swept to all-wall, one entry a cycle, before the
//   first request is taken.
// ----------------------------------------------------------------------------
// grid_line_of_sight_unit
// Wall map of a grid with cell writes and Bresenham line-of-sight queries.
// ----------------------------------------------------------------------------
module grid_line_of_sight_unit #(
  parameter int unsigned MAP_COLS = glos_pkg::GLOS_MAP_COLS_DEF,
  parameter int unsigned MAP_ROWS = glos_pkg::GLOS_MAP_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_col[5:0], start_row[11:6], end_col[17:12], end_row[23:18], wall_value[24]
  input  logic [glos_pkg::GLOS_IN_DATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // line_clear[0]
  output logic [glos_pkg::GLOS_OUT_DATA_W-1:0] m_axis_tdata,
  // answered_command[0]
  output logic [0:0]                           m_axis_tuser
);
  import glos_pkg::*;

  localparam int CW = GLOS_COORD_W;

  glos_cmd_t     cmd;
  glos_sts_t     sts;
  logic [CW-1:0] start_col;
  logic [CW-1:0] start_row;
  logic [CW-1:0] end_col;
  logic [CW-1:0] end_row;
  logic          wall_value;
  logic          line_clear;

  // request fields
  assign start_col  = s_axis_tdata[CW-1:0];
  assign start_row  = s_axis_tdata[2*CW-1:CW];
  assign end_col    = s_axis_tdata[3*CW-1:2*CW];
  assign end_row    = s_axis_tdata[4*CW-1:3*CW];
  assign wall_value = s_axis_tdata[4*CW];

  glos_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser[0]),
    .sts        (sts),
    .cmd        (cmd)
  );

  glos_dp #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_command           (s_axis_tuser[0]),
    .in_start_col         (start_col),
    .in_start_row         (start_row),
    .in_end_col           (end_col),
    .in_end_row           (end_row),
    .in_wall_value        (wall_value),
    .out_valid            (m_axis_tvalid),
    .out_ready            (m_axis_tready),
    .out_line_clear       (line_clear),
    .out_answered_command (m_axis_tuser[0])
  );

  // answer fields
  assign m_axis_tdata = {(GLOS_OUT_DATA_W - 1)'(0), line_clear};

endmodule

// ===== dv/glos_sight_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glos_sight_checker
// Watches both stream channels of the grid line-of-sight unit. It keeps its
// own copy of the wall map and traces its own Bresenham line for every
// accepted query. Each answer is compared field by field, in order, and the
// number of mismatches and of answers still owed is reported to the bench top.
// ----------------------------------------------------------------------------
module glos_sight_checker #(
  parameter int unsigned MAP_COLS = glos_pkg::GLOS_MAP_COLS_DEF,
  parameter int unsigned MAP_ROWS = glos_pkg::GLOS_MAP_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  // start_col[5:0], start_row[11:6], end_col[17:12], end_row[23:18], wall_value[24]
  input  logic [glos_pkg::GLOS_IN_DATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  logic [0:0]                           s_axis_tuser,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // line_clear[0]
  input  logic [glos_pkg::GLOS_OUT_DATA_W-1:0] m_axis_tdata,
  // answered_command[0]
  input  logic [0:0]                           m_axis_tuser,
  output int                                   error_count,
  output int                                   results_pending
);

  import glos_pkg::*;

  typedef struct {
    logic line_clear;
    logic answered_command;
  } sight_answer_t;

  // answers owed by the unit, oldest first
  sight_answer_t owed_answers[$];

  // model copy of the wall map, cell (col,row) at row*MAP_COLS+col
  bit wall_copy[MAP_COLS*MAP_ROWS];

  // cells beyond the map count as wall
  function automatic bit cell_blocked(int col, int row);
    if (col < 0 || row < 0 || col >= int'(MAP_COLS) || row >= int'(MAP_ROWS)) begin
      return 1'b1;
    end
    return wall_copy[row*int'(MAP_COLS) + col];
  endfunction

  // walk the line with the doubled error term, testing only inner cells
  function automatic bit sight_clear(int x0, int y0, int x1, int y1);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    int x;
    int y;
    dx  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    dy  = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    x   = x0;
    y   = y0;
    while (x != x1 || y != y1) begin
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x   += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y   += sy;
      end
      if ((x != x0 || y != y0) && (x != x1 || y != y1)) begin
        if (cell_blocked(x, y)) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    sight_answer_t want;
    sight_answer_t ans;
    logic          cmd;
    int            scol;
    int            srow;
    int            ecol;
    int            erow;
    logic          wall;
    if (rst) begin
      foreach (wall_copy[i]) begin
        wall_copy[i] = 1'b1;
      end
      owed_answers.delete();
      error_count = 0;
    end else begin
      // answer leaving the unit, compared before a new request is taken in
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_answers.size() == 0) begin
          error_count++;
          $display("%0t: answer with none owed: line_clear %0d command %0d", $time,
                   m_axis_tdata[0], m_axis_tuser[0]);
        end else begin
          want = owed_answers.pop_front();
          if (m_axis_tdata[0] !== want.line_clear) begin
            error_count++;
            $display("%0t: line_clear expected %0d actual %0b", $time,
                     want.line_clear, m_axis_tdata[0]);
          end
          if (m_axis_tuser[0] !== want.answered_command) begin
            error_count++;
            $display("%0t: answered_command expected %0d actual %0b", $time,
                     want.answered_command, m_axis_tuser[0]);
          end
        end
      end
      // accepted request: update the map copy or trace the line
      if (s_axis_tvalid && s_axis_tready) begin
        cmd  = s_axis_tuser[0];
        scol = int'(s_axis_tdata[5:0]);
        srow = int'(s_axis_tdata[11:6]);
        ecol = int'(s_axis_tdata[17:12]);
        erow = int'(s_axis_tdata[23:18]);
        wall = s_axis_tdata[24];
        ans.answered_command = cmd;
        if (cmd == GLOS_CMD_WRITE) begin
          if (scol < int'(MAP_COLS) && srow < int'(MAP_ROWS)) begin
            wall_copy[srow*int'(MAP_COLS) + scol] = wall;
          end
          ans.line_clear = 1'b0;
        end else begin
          ans.line_clear = sight_clear(scol, srow, ecol, erow);
        end
        owed_answers = {owed_answers, ans};
      end
    end
    results_pending = owed_answers.size();
  end

endmodule

// ===== dv/tb_grid_line_of_sight_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_line_of_sight_unit
// Drives cell writes and line-of-sight queries into the unit: a short
// directed set of corner cases, then random rooms carved into the map and
// queried, mixed with random noise requests, under three idling mixes and two
// long output hold-offs. The checker beside the unit judges every answer.
// ----------------------------------------------------------------------------
module tb_grid_line_of_sight_unit;

  import glos_pkg::*;

  localparam int COLS = GLOS_MAP_COLS_DEF;
  localparam int ROWS = GLOS_MAP_ROWS_DEF;

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [GLOS_IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]                 s_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [GLOS_OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                 m_axis_tuser;

  int error_count;
  int results_pending;
  int requests_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int holds_asked;

  grid_line_of_sight_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  glos_sight_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // answer side: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_seen;
    hold_left     = 0;
    holds_seen    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // one request, entered and left at a falling edge
  task automatic send_request(logic cmd, int scol, int srow, int ecol, int erow, logic wall);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, wall, 6'(erow), 6'(ecol), 6'(srow), 6'(scol)};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    requests_sent++;
    @(negedge clk);
  endtask

  // fully random request
  task automatic send_noise();
    send_request(logic'($urandom_range(1)), $urandom_range(63), $urandom_range(63),
                 $urandom_range(63), $urandom_range(63), logic'($urandom_range(1)));
  endtask

  // stop offering and wait for every owed answer
  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
  endtask

  // clear a room with a few scattered walls, then look across it
  task automatic carve_room();
    int c0;
    int r0;
    int w;
    int h;
    int qc;
    int qr;
    c0 = $urandom_range(COLS - 1);
    r0 = $urandom_range(ROWS - 1);
    if ($urandom_range(9) == 0) begin
      // long thin corridor for long lines
      if ($urandom_range(1) == 1) begin
        w = $urandom_range(COLS, 16);
        h = $urandom_range(3, 1);
      end else begin
        w = $urandom_range(3, 1);
        h = $urandom_range(ROWS, 16);
      end
    end else begin
      w = $urandom_range(8, 1);
      h = $urandom_range(8, 1);
    end
    if (c0 + w > COLS) c0 = COLS - w;
    if (r0 + h > ROWS) r0 = ROWS - h;
    for (int r = r0; r < r0 + h; r++) begin
      for (int c = c0; c < c0 + w; c++) begin
        send_request(GLOS_CMD_WRITE, c, r, $urandom_range(63), $urandom_range(63),
                     logic'($urandom_range(99) < 12));
      end
    end
    repeat ($urandom_range(10, 2)) begin
      qc = c0 + $urandom_range(w - 1);
      qr = r0 + $urandom_range(h - 1);
      if ($urandom_range(5) == 0) begin
        send_request(GLOS_CMD_QUERY, qc, qr, $urandom_range(63), $urandom_range(63),
                     logic'($urandom_range(1)));
      end else begin
        send_request(GLOS_CMD_QUERY, qc, qr, c0 + $urandom_range(w - 1),
                     r0 + $urandom_range(h - 1), logic'($urandom_range(1)));
      end
    end
  endtask

  // random mix of rooms and noise until the request budget is spent
  task automatic run_random(int budget);
    int first;
    first = requests_sent;
    while (requests_sent - first < budget) begin
      if ($urandom_range(99) < 20) begin
        send_noise();
      end else begin
        carve_room();
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    requests_sent = 0;
    holds_asked   = 0;
    tx_idle_pct   = 21;
    rx_idle_pct   = 66;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: same cell, adjacent cells, full diagonal on an all-wall map
    send_request(GLOS_CMD_QUERY, 0, 0, 0, 0, 1'b1);
    send_request(GLOS_CMD_QUERY, 63, 63, 63, 63, 1'b0);
    send_request(GLOS_CMD_QUERY, 0, 0, 63, 63, 1'b0);
    send_request(GLOS_CMD_QUERY, 5, 5, 6, 6, 1'b1);
    // short lines through single cleared cells, both directions
    send_request(GLOS_CMD_WRITE, 1, 0, 63, 63, 1'b0);
    send_request(GLOS_CMD_QUERY, 0, 0, 2, 0, 1'b0);
    send_request(GLOS_CMD_QUERY, 2, 0, 0, 0, 1'b0);
    send_request(GLOS_CMD_WRITE, 0, 1, 0, 0, 1'b0);
    send_request(GLOS_CMD_QUERY, 0, 0, 0, 2, 1'b0);
    send_request(GLOS_CMD_WRITE, 1, 1, 63, 0, 1'b0);
    send_request(GLOS_CMD_QUERY, 2, 2, 0, 0, 1'b1);
    send_request(GLOS_CMD_QUERY, 0, 0, 1, 2, 1'b0);
    send_request(GLOS_CMD_QUERY, 0, 0, 2, 1, 1'b0);
    // wall put back blocks the line
    send_request(GLOS_CMD_WRITE, 1, 0, 0, 63, 1'b1);
    send_request(GLOS_CMD_QUERY, 0, 0, 2, 0, 1'b0);
    // far corner: end cells themselves are never tested
    send_request(GLOS_CMD_WRITE, 63, 63, 63, 63, 1'b0);
    send_request(GLOS_CMD_WRITE, 62, 62, 0, 0, 1'b0);
    send_request(GLOS_CMD_QUERY, 61, 61, 63, 63, 1'b0);
    send_request(GLOS_CMD_WRITE, 63, 63, 63, 63, 1'b1);
    send_request(GLOS_CMD_QUERY, 61, 61, 63, 63, 1'b1);
    send_request(GLOS_CMD_QUERY, 0, 63, 63, 0, 1'b1);
    send_request(GLOS_CMD_WRITE, 0, 63, 0, 0, 1'b0);

    run_random(560);
    drain_answers();

    // sender mostly idle, receiver mostly ready; first a long output hold-off
    tx_idle_pct = 66;
    rx_idle_pct = 21;
    holds_asked++;
    repeat (8) send_noise();
    run_random(560);
    drain_answers();

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(300);
    drain_answers();
    holds_asked++;
    repeat (8) send_noise();
    run_random(300);
    drain_answers();

    repeat (100) @(negedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
